@@ hdl/dodn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Date offset package
// Shared types, microcode table and calendar helpers for the date offset block.
// ----------------------------------------------------------------------------
package dodn_pkg;

  localparam int unsigned MaxDayNumber = 3652059;
  localparam int unsigned DaysPerYear  = 365;
  localparam int unsigned RecipMul25   = 5243;  // 2^17 / 25, rounded up
  localparam int unsigned RecipShift   = 17;

  typedef logic [3:0] step_t;

  localparam step_t S_WAIT   = 4'd0;
  localparam step_t S_CLAMP  = 4'd1;
  localparam step_t S_Q4     = 4'd2;
  localparam step_t S_C100   = 4'd3;
  localparam step_t S_C400   = 4'd4;
  localparam step_t S_MONTH  = 4'd5;
  localparam step_t S_DAY    = 4'd6;
  localparam step_t S_OFFSET = 4'd7;
  localparam step_t S_RANGE  = 4'd8;
  localparam step_t S_DIR    = 4'd9;
  localparam step_t S_FWD    = 4'd10;
  localparam step_t S_BACK   = 4'd11;
  localparam step_t S_FIN    = 4'd12;
  localparam step_t S_DONE   = 4'd13;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_OUT_RANGE,
    C_R_NEG,
    C_FIT_FWD,
    C_FIT_BACK,
    C_OUT_FREE
  } cond_t;

  typedef enum logic [3:0] {
    A_NOP,
    A_LOAD,
    A_CLAMP,
    A_ADD_Q4,
    A_SUB_C100,
    A_ADD_C400,
    A_ADD_MONTH,
    A_ADD_DAY,
    A_ADD_OFF,
    A_SET_FLAG,
    A_FWD_MONTH,
    A_BACK_MONTH,
    A_FINISH,
    A_EMIT
  } act_t;

  typedef enum logic [1:0] {
    G_ALWAYS,
    G_TRUE,
    G_FALSE
  } gate_t;

  typedef struct packed {
    cond_t cond;
    step_t jt;
    step_t jf;
    act_t  act;
    gate_t gate;
  } ctrl_t;

  typedef struct packed {
    act_t act;
    logic en;
    logic idle;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic out_range;
    logic r_neg;
    logic fit_fwd;
    logic fit_back;
  } stat_t;

  // Microcode program: one control word per step.
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = '{cond: C_ALWAYS, jt: S_WAIT, jf: S_WAIT, act: A_NOP, gate: G_ALWAYS};
    unique case (s)
      S_WAIT:   c = '{cond: C_IN_VALID, jt: S_CLAMP, jf: S_WAIT, act: A_LOAD, gate: G_TRUE};
      S_CLAMP:  c = '{cond: C_ALWAYS, jt: S_Q4, jf: S_Q4, act: A_CLAMP, gate: G_ALWAYS};
      S_Q4:     c = '{cond: C_ALWAYS, jt: S_C100, jf: S_C100, act: A_ADD_Q4, gate: G_ALWAYS};
      S_C100:   c = '{cond: C_ALWAYS, jt: S_C400, jf: S_C400, act: A_SUB_C100,
                      gate: G_ALWAYS};
      S_C400:   c = '{cond: C_ALWAYS, jt: S_MONTH, jf: S_MONTH, act: A_ADD_C400,
                      gate: G_ALWAYS};
      S_MONTH:  c = '{cond: C_ALWAYS, jt: S_DAY, jf: S_DAY, act: A_ADD_MONTH,
                      gate: G_ALWAYS};
      S_DAY:    c = '{cond: C_ALWAYS, jt: S_OFFSET, jf: S_OFFSET, act: A_ADD_DAY,
                      gate: G_ALWAYS};
      S_OFFSET: c = '{cond: C_ALWAYS, jt: S_RANGE, jf: S_RANGE, act: A_ADD_OFF,
                      gate: G_ALWAYS};
      S_RANGE:  c = '{cond: C_OUT_RANGE, jt: S_DONE, jf: S_DIR, act: A_SET_FLAG,
                      gate: G_TRUE};
      S_DIR:    c = '{cond: C_R_NEG, jt: S_BACK, jf: S_FWD, act: A_NOP, gate: G_ALWAYS};
      S_FWD:    c = '{cond: C_FIT_FWD, jt: S_FIN, jf: S_FWD, act: A_FWD_MONTH,
                      gate: G_FALSE};
      S_BACK:   c = '{cond: C_FIT_BACK, jt: S_FIN, jf: S_BACK, act: A_BACK_MONTH,
                      gate: G_FALSE};
      S_FIN:    c = '{cond: C_ALWAYS, jt: S_DONE, jf: S_DONE, act: A_FINISH, gate: G_ALWAYS};
      S_DONE:   c = '{cond: C_OUT_FREE, jt: S_WAIT, jf: S_DONE, act: A_EMIT, gate: G_TRUE};
      default:  c = '{cond: C_ALWAYS, jt: S_WAIT, jf: S_WAIT, act: A_NOP, gate: G_ALWAYS};
    endcase
    return c;
  endfunction

  // Quotient by 25 through a reciprocal, exact for any 14-bit value.
  function automatic logic [9:0] div25(input logic [13:0] x);
    logic [26:0] prod;
    prod = 27'(x) * 27'(RecipMul25);
    return prod[RecipShift +: 10];
  endfunction

  // Leap year: divisible by 4 and (not by 25, or by 16).
  function automatic logic leap_f(input logic [13:0] y);
    logic [9:0]  q;
    logic [13:0] back;
    q    = div25(y);
    back = 14'(q) * 14'd25;
    return (y[1:0] == 2'd0) && ((back != y) || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] days_of(input logic [3:0] m, input logic lp);
    logic [4:0] n;
    unique case (m)
      4'd2:                      n = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  // Days before the first of the month in a common year.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ hdl/dodn_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Date offset input channel
// Valid/ready channel carrying an input date and a signed day offset.
// ----------------------------------------------------------------------------
interface dodn_in_if;
  logic               valid;
  logic               ready;
  logic        [4:0]  day;
  logic        [3:0]  month;
  logic        [13:0] year;
  logic signed [15:0] day_offset;

  modport source (output valid, output day, output month, output year,
                  output day_offset, input ready);
  modport sink   (input valid, input day, input month, input year,
                  input day_offset, output ready);
endinterface
`default_nettype wire

@@ hdl/dodn_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Date offset output channel
// Valid/ready channel carrying the moved date and the day number.
// ----------------------------------------------------------------------------
interface dodn_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  res_day;
  logic [3:0]  res_month;
  logic [13:0] res_year;
  logic [21:0] day_number;
  logic        out_of_range;

  modport source (output valid, output res_day, output res_month, output res_year,
                  output day_number, output out_of_range, input ready);
  modport sink   (input valid, input res_day, input res_month, input res_year,
                  input day_number, input out_of_range, output ready);
endinterface
`default_nettype wire

@@ hdl/dodn_ucode_rom.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Date offset microcode ROM
// Maps the step counter to its control word.
// ----------------------------------------------------------------------------
module dodn_ucode_rom
  import dodn_pkg::*;
(
  input  step_t step,
  output ctrl_t ctrl
);

  assign ctrl = ucode(step);

endmodule
`default_nettype wire

@@ hdl/dodn_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Date offset sequencer
// Step counter with two-way conditional jumps, driving the datapath.
// ----------------------------------------------------------------------------
module dodn_sequencer
  import dodn_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd
);

  step_t step;
  step_t step_next;
  ctrl_t ctrl;
  logic  cond_hit;

  dodn_ucode_rom u_rom (
    .step (step),
    .ctrl (ctrl)
  );

  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:    cond_hit = 1'b1;
      C_IN_VALID:  cond_hit = stat.in_valid;
      C_OUT_RANGE: cond_hit = stat.out_range;
      C_R_NEG:     cond_hit = stat.r_neg;
      C_FIT_FWD:   cond_hit = stat.fit_fwd;
      C_FIT_BACK:  cond_hit = stat.fit_back;
      C_OUT_FREE:  cond_hit = stat.out_free;
      default:     cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    step_next = cond_hit ? ctrl.jt : ctrl.jf;
    cmd.act   = ctrl.act;
    cmd.idle  = (step == S_WAIT);
    unique case (ctrl.gate)
      G_ALWAYS: cmd.en = 1'b1;
      G_TRUE:   cmd.en = cond_hit;
      G_FALSE:  cmd.en = !cond_hit;
      default:  cmd.en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/dodn_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Date offset datapath
// Date registers, day-number accumulator, month walker and output register.
// ----------------------------------------------------------------------------
module dodn_datapath
  import dodn_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  dodn_in_if.sink       in_ch,
  dodn_out_if.source    out_ch,
  input  cmd_t          cmd,
  output stat_t         stat
);

  logic [4:0]  d;
  logic [3:0]  m;
  logic [13:0] y;
  logic [16:0] r;          // remaining offset, two's complement
  logic [23:0] acc;        // two's complement
  logic [21:0] dn;
  logic        flag;
  logic        out_valid;

  logic [13:0] p;
  logic        lp;
  logic [4:0]  len_cur;
  logic [4:0]  len_prev;
  logic [3:0]  m_prev;
  logic [16:0] r_plus_d;
  logic [3:0]  m_sat;
  logic [13:0] y_sat;
  logic        do_emit;

  assign p        = y - 14'd1;
  assign lp       = leap_f(y);
  assign len_cur  = days_of(m, lp);
  assign m_prev   = (m == 4'd1) ? 4'd12 : m - 4'd1;
  assign len_prev = days_of(m_prev, lp);   // December is 31 days in any year
  assign r_plus_d = r + 17'(d);

  assign m_sat = (in_ch.month == 4'd0) ? 4'd1 :
                 (in_ch.month > 4'd12) ? 4'd12 : in_ch.month;
  assign y_sat = (in_ch.year == 14'd0) ? 14'd1 :
                 (in_ch.year > 14'd9999) ? 14'd9999 : in_ch.year;

  assign stat.in_valid  = in_ch.valid;
  assign stat.out_free  = !out_valid || out_ch.ready;
  assign stat.out_range = acc[23] || (acc == 24'd0) || (acc > 24'(MaxDayNumber));
  assign stat.r_neg     = r[16];
  assign stat.fit_fwd   = r_plus_d <= 17'(len_cur);
  assign stat.fit_back  = !r_plus_d[16] && (r_plus_d != 17'd0);

  assign do_emit = cmd.en && (cmd.act == A_EMIT);

  assign in_ch.ready         = cmd.idle;
  assign out_ch.valid        = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_ch.res_day      <= d;
      out_ch.res_month    <= m;
      out_ch.res_year     <= y;
      out_ch.day_number   <= dn;
      out_ch.out_of_range <= flag;
    end
    if (cmd.en) begin
      unique case (cmd.act)
        A_LOAD: begin
          d    <= in_ch.day;
          m    <= m_sat;
          y    <= y_sat;
          r    <= {in_ch.day_offset[15], in_ch.day_offset};
          flag <= 1'b0;
        end
        A_CLAMP: begin
          // Clamp day into the month, start the day count with whole years.
          d   <= (d == 5'd0) ? 5'd1 : (d > len_cur) ? len_cur : d;
          acc <= 24'(p) * 24'(DaysPerYear);
        end
        A_ADD_Q4:    acc <= acc + 24'(p[13:2]);
        A_SUB_C100:  acc <= acc - 24'(div25(14'(p[13:2])));
        A_ADD_C400:  acc <= acc + 24'(div25(14'(p[13:4])));
        A_ADD_MONTH: acc <= acc + 24'(month_start(m)) + 24'((m > 4'd2) && lp);
        A_ADD_DAY:   acc <= acc + 24'(d);
        A_ADD_OFF: begin
          dn  <= acc[21:0];
          acc <= acc + {{7{r[16]}}, r};
        end
        A_SET_FLAG:  flag <= 1'b1;
        A_FWD_MONTH: begin
          // Drop the rest of this month, advance to the first of the next.
          r <= r - 17'(len_cur) + 17'(d) - 17'd1;
          d <= 5'd1;
          if (m == 4'd12) begin
            m <= 4'd1;
            y <= y + 14'd1;
          end else begin
            m <= m + 4'd1;
          end
        end
        A_BACK_MONTH: begin
          // Step back to the last day of the previous month.
          r <= r_plus_d;
          d <= len_prev;
          m <= m_prev;
          if (m == 4'd1) begin
            y <= y - 14'd1;
          end
        end
        A_FINISH: d <= d + r[4:0];
        A_NOP, A_EMIT: ;
        default: ;
      endcase
    end
  end

  a_accept_drops_ready: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted twice without finishing an item");

  a_result_month_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ch.res_month >= 4'd1) && (out_ch.res_month <= 4'd12)
                  && (out_ch.res_day != 5'd0))
    else $error("result date not legal");

  a_fwd_walk_sign: assert property (@(posedge clk) disable iff (rst)
    cmd.en && (cmd.act == A_FWD_MONTH) |-> !r[16])
    else $error("forward month walk with negative remainder");

  a_back_walk_sign: assert property (@(posedge clk) disable iff (rst)
    cmd.en && (cmd.act == A_BACK_MONTH) |-> r[16])
    else $error("backward month walk with non-negative remainder");

endmodule
`default_nettype wire

@@ hdl/date_offset_and_day_number_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gregorian date offset and day number
// Moves a date by a signed day offset and reports its day number from 1/1/1.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time: a date and a signed offset in,
// one result out. Out-of-range input fields are saturated first (month to
// 1..12, year to 1..9999, day to 1..last day of the month), and the day
// number is that of the saturated date. The month walker then moves the
// date one month per cycle, forward or back, until the rest of the offset
// fits in the month. If the moved date falls outside 1/1/1..31/12/9999 the
// walk is skipped, out_of_range is raised and the saturated input date is
// returned. The result sits in an output register until taken; the next
// input is accepted once the result has been handed to that register.
// ----------------------------------------------------------------------------
module date_offset_and_day_number_top
  import dodn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dodn_in_if.sink     in_ch,
  dodn_out_if.source  out_ch
);

  // Control word actions and datapath status between the two halves.
  cmd_t  cmd;
  stat_t stat;

  // Step counter, microcode ROM and jump logic.
  dodn_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Date registers, day-number accumulator and month walker.
  dodn_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule
`default_nettype wire
